// File: hw/rtl/recho_pkg.sv
// Shared types and constants for the recursive echo filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package recho_pkg;

    // Filter geometry
    localparam int TAPS   = 10;
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int HIST_N = TAPS - 1;
    localparam int HIST_W = (HIST_N > 1) ? $clog2(HIST_N) : 1;

    // Field widths
    localparam int SMP_W  = 16;
    localparam int COEF_W = 16;
    localparam int IDX_W  = 4;

    // Datapath widths: operand A carries gain + c0, so one bit more than a coefficient
    localparam int OPA_W  = COEF_W + 1;
    localparam int PROD_W = OPA_W + SMP_W;
    localparam int ACC_W  = PROD_W + TAP_W + 1;

    // Q1.15 constants
    localparam int GAIN_Q15 = 3277;    // 0.1
    localparam int HALF_Q15 = 16384;   // 0.5, also the rounding offset
    localparam int HALF_TAP = 9;       // tap that resets to 0.5
    localparam int FRAC_W   = 15;
    localparam int SAT_MAX  = 32767;
    localparam int SAT_MIN  = -32768;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic issue;   // operands valid this cycle
        logic first;   // first term of a new sum
    } t_mac_ctrl;

    typedef struct packed {
        t_mac_ctrl              mac;
        logic [TAP_W-1:0]       tap;
        logic                   fin;    // result written, history shifts
        logic                   busy;
    } t_seq_ctrl;

    typedef struct packed {
        logic start;      // audio sample transfer
        logic out_free;   // output register can take a result
    } t_seq_stat;

endpackage

// File: hw/rtl/recho_mac.sv
// Shared multiply-accumulate unit: registered product, then wide accumulator.
// Depends on recho_pkg.
`timescale 1ns / 1ps

module recho_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  recho_pkg::t_mac_ctrl               i_ctrl,
    input  logic signed [recho_pkg::OPA_W-1:0] i_a,
    input  logic signed [recho_pkg::SMP_W-1:0] i_b,
    output logic signed [recho_pkg::ACC_W-1:0] o_acc
);
    import recho_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_p_vld;
    logic                     r_p_first;

    // Product stage valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_p_first <= 1'b0;
        end else begin
            r_p_vld   <= i_ctrl.issue;
            r_p_first <= i_ctrl.first;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_prod <= i_a * i_b;
        end
    end

    // Accumulate stage
    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            if (r_p_first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

// File: hw/rtl/recho_seq.sv
// Sequencer: walks the taps through the shared MAC, one tap per cycle.
// Depends on recho_pkg.
`timescale 1ns / 1ps

module recho_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  recho_pkg::t_seq_stat  i_stat,
    output recho_pkg::t_seq_ctrl  o_ctrl
);
    import recho_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [TAP_W-1:0] r_tap;
    logic [TAP_W-1:0] n_tap;
    logic             w_last;

    assign w_last = (r_tap == TAP_W'(TAPS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_stat.start)   n_state = S_MAC;
            S_MAC:   if (w_last)         n_state = S_DRAIN;
            S_DRAIN:                     n_state = S_FIN;
            S_FIN:   if (i_stat.out_free) n_state = S_IDLE;
            default:                     n_state = S_IDLE;
        endcase
    end

    // Tap counter
    always_comb begin
        n_tap = r_tap;
        if (r_state == S_IDLE) begin
            n_tap = '0;
        end else if (r_state == S_MAC && !w_last) begin
            n_tap = r_tap + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    // Outputs
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.tap       = r_tap;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.busy = 1'b0;
            end
            S_MAC: begin
                o_ctrl.busy      = 1'b1;
                o_ctrl.mac.issue = 1'b1;
                o_ctrl.mac.first = (r_tap == '0);
            end
            S_DRAIN: begin
                o_ctrl.busy = 1'b1;
            end
            S_FIN: begin
                o_ctrl.busy = 1'b1;
                o_ctrl.fin  = i_stat.out_free;
            end
            default: begin
                o_ctrl.busy = 1'b1;
            end
        endcase
    end

    // Checks
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.mac.issue |-> (r_tap <= TAP_W'(TAPS - 1)))
        else $error("tap counter out of range");

    a_start_tap0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_stat.start) |=> (r_state == S_MAC && r_tap == '0))
        else $error("sum did not start at tap zero");

    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && w_last) |=> (r_state == S_DRAIN))
        else $error("missing drain after last tap");

endmodule

// File: hw/rtl/recursive_echo_filter_core.sv
// Top level of the recursive echo filter: coefficient table, output history,
// operand select, rounding/saturation, output register. Uses recho_pkg,
// recho_seq and recho_mac.
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_kind, i_sample, i_coef_index, i_coef_value
// output   out        o_valid / i_stall   o_echo_sample
//
// A coefficient load is taken while idle. An audio sample passes through these
// states: the idle state that takes the transfer, one MAC issue per tap
// through the single shared multiplier, a drain state for the accumulator, and a
// final state that rounds and writes the output register.
// Synchronous active-low reset restores the coefficient table (tap 9 = 0.5) and
// clears the history. The result waits in the output register; if it is still
// stalled when the next sum finishes, the sequencer holds in its final state.

module recursive_echo_filter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_kind,
    input  logic signed [recho_pkg::SMP_W-1:0]   i_sample,
    input  logic        [recho_pkg::IDX_W-1:0]   i_coef_index,
    input  logic signed [recho_pkg::COEF_W-1:0]  i_coef_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [recho_pkg::SMP_W-1:0]   o_echo_sample
);
    import recho_pkg::*;

    t_seq_ctrl                 w_ctrl;
    t_seq_stat                 w_stat;
    logic                      w_xfer;

    logic signed [COEF_W-1:0]  r_coef [TAPS];
    logic signed [OPA_W-1:0]   r_c0g;           // gain + c0
    logic signed [SMP_W-1:0]   r_hist [HIST_N];
    logic signed [SMP_W-1:0]   r_sample;

    logic                      r_out_vld;
    logic signed [SMP_W-1:0]   r_echo;

    logic [TAP_W-1:0]          w_hprev;
    logic [HIST_W-1:0]         w_hidx;
    logic signed [OPA_W-1:0]   w_a;
    logic signed [SMP_W-1:0]   w_b;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [ACC_W-1:0]   w_rnd;
    logic signed [SMP_W-1:0]   w_y;

    assign w_xfer          = i_valid && !o_stall;
    assign o_stall         = w_ctrl.busy;
    assign w_stat.start    = w_xfer && (i_kind == KIND_SAMPLE);
    assign w_stat.out_free = !r_out_vld || !i_stall;

    recho_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Coefficient table; out-of-range taps are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_coef[i] <= (i == HALF_TAP) ? COEF_W'(HALF_Q15) : '0;
            end
            r_c0g <= OPA_W'(GAIN_Q15);
        end else if (w_xfer && i_kind == KIND_COEF && int'(i_coef_index) < TAPS) begin
            r_coef[TAP_W'(i_coef_index)] <= i_coef_value;
            if (i_coef_index == '0) begin
                r_c0g <= OPA_W'(i_coef_value) + OPA_W'(GAIN_Q15);
            end
        end
    end

    // Sample capture
    always_ff @(posedge i_clk) begin
        if (w_stat.start) begin
            r_sample <= i_sample;
        end
    end

    // Operand select: tap 0 uses gain + c0 against x, others ck against y[n-k]
    assign w_hprev = w_ctrl.tap - 1'b1;
    assign w_hidx  = w_hprev[HIST_W-1:0];
    assign w_a     = (w_ctrl.tap == '0) ? r_c0g : OPA_W'(r_coef[w_ctrl.tap]);
    assign w_b     = (w_ctrl.tap == '0) ? r_sample : r_hist[w_hidx];

    recho_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl.mac),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_acc   (w_acc)
    );

    // Round half up, then saturate
    assign w_rnd = (w_acc + ACC_W'(HALF_Q15)) >>> FRAC_W;

    always_comb begin
        if (w_rnd > ACC_W'(SAT_MAX)) begin
            w_y = SMP_W'(SAT_MAX);
        end else if (w_rnd < ACC_W'(SAT_MIN)) begin
            w_y = SMP_W'(SAT_MIN);
        end else begin
            w_y = w_rnd[SMP_W-1:0];
        end
    end

    // Output history: shift line, newest at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_N; i++) begin
                r_hist[i] <= '0;
            end
        end else if (w_ctrl.fin) begin
            r_hist[0] <= w_y;
            for (int i = 1; i < HIST_N; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ctrl.fin) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.fin) begin
            r_echo <= w_y;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_echo_sample = r_echo;

    // Checks
    a_out_on_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.fin |=> o_valid)
        else $error("finished sum did not reach the output");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |-> !w_ctrl.fin)
        else $error("result overwritten while stalled");

    a_hist_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.fin |=> (r_hist[0] == r_echo))
        else $error("history does not hold the last output");

endmodule
